// File: rtl/core/crc32_word_stream_macros.svh
// Assertion macros shared by the word-stream CRC modules.
`ifndef CRC32_WORD_STREAM_MACROS_SVH
`define CRC32_WORD_STREAM_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check an implication at every clock edge outside reset.
`define CRC32W_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define CRC32W_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CRC32W_ASSERT(label, clk, rst_n, prop, msg)
`define CRC32W_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/core/crc32w_pkg.sv
// Types, constants and XOR-matrix functions for the word-stream CRC-32.
package crc32w_pkg;

    localparam int CRC_W = 32;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    // One row per CRC output bit: which input bits feed it.
    typedef logic [CRC_W-1:0][CRC_W-1:0] t_mask_tbl;

    // Beat passed from the input register to the update stage.
    typedef struct packed {
        logic             valid;
        logic [CRC_W-1:0] data;
        logic             first;
        logic             last;
    } t_beat;

    // Bit-serial reference update, MSB first; used only to build the tables and the zero-word constant.
    function automatic logic [CRC_W-1:0] crc_serial(input logic [CRC_W-1:0] crc_in,
                                                    input logic [CRC_W-1:0] data);
        logic [CRC_W-1:0] crc;
        logic             fb;
        crc = crc_in;
        for (int b = CRC_W - 1; b >= 0; b--) begin
            fb  = crc[CRC_W-1] ^ data[b];
            crc = {crc[CRC_W-2:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    // Transpose the response to single set bits into per-output-bit masks.
    function automatic t_mask_tbl build_rows(input logic from_data);
        t_mask_tbl        rows;
        logic [CRC_W-1:0] unit;
        logic [CRC_W-1:0] col;
        rows = '0;
        for (int j = 0; j < CRC_W; j++) begin
            unit = {{(CRC_W-1){1'b0}}, 1'b1} << j;
            col  = from_data ? crc_serial('0, unit) : crc_serial(unit, '0);
            for (int i = 0; i < CRC_W; i++) begin
                rows[i][j] = col[i];
            end
        end
        return rows;
    endfunction

    localparam t_mask_tbl ROW_C = build_rows(1'b0);
    localparam t_mask_tbl ROW_D = build_rows(1'b1);

    // CRC of an all-zero word from the initial value.
    localparam logic [CRC_W-1:0] CRC_ZERO_WORD = crc_serial(CRC_INIT, '0);

    // Word-parallel update: each output bit is an XOR over masked state and data.
    function automatic logic [CRC_W-1:0] crc_word(input logic [CRC_W-1:0] crc,
                                                  input logic [CRC_W-1:0] data);
        logic [CRC_W-1:0] nxt;
        for (int i = 0; i < CRC_W; i++) begin
            nxt[i] = (^(crc & ROW_C[i])) ^ (^(data & ROW_D[i]));
        end
        return nxt;
    endfunction

endpackage

// File: rtl/core/crc32w_in_stage.sv
// Input register: captures one beat and holds it until the update stage takes it.
`include "crc32_word_stream_macros.svh"

module crc32w_in_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [crc32w_pkg::CRC_W-1:0] i_data,
    input  logic                          i_first,
    input  logic                          i_last,
    input  logic                          i_take,
    output crc32w_pkg::t_beat             o_beat
);

    logic                         r_valid;
    logic                         n_valid;
    logic [crc32w_pkg::CRC_W-1:0] r_data;
    logic                         r_first;
    logic                         r_last;

    // Free when empty or when the held beat leaves this cycle.
    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data  <= i_data;
            r_first <= i_first;
            r_last  <= i_last;
        end
    end

    assign o_beat = '{valid: r_valid, data: r_data, first: r_first, last: r_last};

    `CRC32W_ASSERT(a_take_needs_beat, i_clk, i_rst_n, i_take |-> r_valid, "take without held beat")
    `CRC32W_ASSERT_NEXT(a_hold_beat, i_clk, i_rst_n, r_valid && !i_take, r_valid && $stable(r_data), "held beat lost")

endmodule

// File: rtl/core/crc32w_update.sv
// CRC update stage: word-parallel XOR network into the running CRC / result register.
`include "crc32_word_stream_macros.svh"

module crc32w_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crc32w_pkg::t_beat             i_beat,
    output logic                          o_take,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [crc32w_pkg::CRC_W-1:0] o_crc,
    output logic                          o_done
);

    logic                         r_out_valid;
    logic                         n_out_valid;
    logic [crc32w_pkg::CRC_W-1:0] r_crc;
    logic [crc32w_pkg::CRC_W-1:0] n_crc;
    logic [crc32w_pkg::CRC_W-1:0] w_crc_base;
    logic                         r_done;

    // Advance when the result register is empty or being drained.
    assign o_take = i_beat.valid && (!r_out_valid || i_ready);

    always_comb begin
        w_crc_base  = i_beat.first ? crc32w_pkg::CRC_INIT : r_crc;
        n_crc       = r_crc;
        n_out_valid = r_out_valid && !i_ready;
        if (o_take) begin
            n_crc       = crc32w_pkg::crc_word(w_crc_base, i_beat.data);
            n_out_valid = 1'b1;
        end
    end

    // The running CRC doubles as the result data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_crc       <= crc32w_pkg::CRC_INIT;
        end else begin
            r_out_valid <= n_out_valid;
            r_crc       <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_done <= i_beat.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_crc   = r_crc;
    assign o_done  = r_done;

    `CRC32W_ASSERT_NEXT(a_stall_holds_crc, i_clk, i_rst_n, r_out_valid && !i_ready, $stable(r_crc), "CRC moved while stalled")
    `CRC32W_ASSERT_NEXT(a_zero_word_restart, i_clk, i_rst_n, o_take && i_beat.first && (i_beat.data == '0), r_crc == crc32w_pkg::CRC_ZERO_WORD, "restart on zero word wrong")
    `CRC32W_ASSERT_NEXT(a_take_gives_result, i_clk, i_rst_n, o_take, r_out_valid, "accepted word left no result")

endmodule

// File: rtl/core/crc32_word_stream.sv
// Top level of the word-stream CRC-32 (MPEG-2: poly 04C11DB7, init all ones).
// Running CRC-32/MPEG-2 over a stream of 32-bit words, MSB first, no reflection and no
// final XOR. tuser on the input marks the first word of a message and reloads the CRC
// with all ones before that word; tlast marks the last word and comes back as tlast on
// the result. Every input beat yields one result beat carrying the CRC after that word.
// Throughput is one word per clock unless the output stalls; a word passes the input
// register, then one XOR network of 64-input parity trees into the CRC/result register.
// After reset the CRC is all ones, so a first word without tuser gives the same result.
module crc32_word_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] data_word
    input  logic        i_s_axis_tuser,   // [0] first_word
    input  logic        i_s_axis_tlast,   // last_word
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] crc_value
    output logic        o_m_axis_tlast    // crc_done
);

    crc32w_pkg::t_beat w_beat;
    logic              w_take;

    crc32w_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_first (i_s_axis_tuser),
        .i_last  (i_s_axis_tlast),
        .i_take  (w_take),
        .o_beat  (w_beat)
    );

    crc32w_update u_update (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_beat),
        .o_take  (w_take),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_crc   (o_m_axis_tdata),
        .o_done  (o_m_axis_tlast)
    );

endmodule
